FILE: sv/edf_dispatcher_with_deadline_drop_unit_assert.svh
// Assertion macros for the EDF dispatcher.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EDF_DISPATCHER_WITH_DEADLINE_DROP_UNIT_ASSERT_SVH
`define EDF_DISPATCHER_WITH_DEADLINE_DROP_UNIT_ASSERT_SVH

// same-cycle implication
`define EDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/edf_pkg.sv
// Shared types and constants for the EDF dispatcher.
// No dependencies.
package edf_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int SLOT_W = 8;

	localparam logic OP_SUBMIT = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_MISS = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [15:0] task_id;
		logic [15:0] burst;
		logic [31:0] arrival;
		logic [31:0] deadline;
		logic [7:0]  priority_req;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] out_task_id;
		logic [31:0] finish_time;
		logic [31:0] turnaround;
		logic [31:0] wait_time;
		logic [15:0] missed_total;
		logic        halted_flag;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic              v;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       id;
		logic [15:0]       burst;
		logic [31:0]       arr;
		logic [31:0]       dl;
		logic [7:0]        pr;
	} cand_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FIN
	} state_t;

endpackage

FILE: sv/edf_dispatcher_with_deadline_drop_unit.sv
// Top level of the EDF dispatcher with deadline drop.
// Uses edf_pkg, edf_cell and edf_dispatcher_with_deadline_drop_unit_assert.svh.
//
// A submit word is taken while busy stays low. A rejected submit
// gives its single result word in the cycle after it is taken. A step word
// makes one pick per dropped task plus one. Each pick passes the candidate
// through the chain of slot cells, one cell per cycle, in ST_SCAN and then
// decides in ST_DECIDE; a task that runs adds ST_FIN. The last result word
// is on the ports in the first cycle with busy low. A step while halted is
// taken with no result. Results are strobed by result_valid for one cycle
// each and cannot be stalled; the receiver must take every word.
module edf_dispatcher_with_deadline_drop_unit #(
	parameter int TABLE_DEPTH = edf_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  edf_pkg::in_word_t   cmd,
	output logic                result_valid,
	output edf_pkg::out_word_t  result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	edf_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0]  cnt_q;
	logic [31:0]       now_q;
	logic [15:0]       missed_q;
	logic              halted_q;
	logic              hard_q;
	edf_pkg::out_word_t pend_q;
	logic              pend_v_q;
	edf_pkg::out_word_t res_q;
	logic              res_v_q;
	logic [31:0]       run_arr_q;
	logic [15:0]       run_burst_q;

	edf_pkg::cand_t    chain [TABLE_DEPTH+1];
	edf_pkg::cand_t    best;
	edf_pkg::cell_ctl_t ctl [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_vec;

	logic              accept;
	logic              bad;
	logic              reject;
	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic              wr_en;
	logic              clr_en;
	logic [32:0]       fin64;
	logic              miss;
	logic [31:0]       fin_sat;
	logic [15:0]       missed_inc;
	logic [31:0]       now_inc;
	logic [31:0]       tat;
	logic [31:0]       wt;
	logic              step_go;
	logic              done_out;

	assign chain[0] = '0;
	assign best = chain[TABLE_DEPTH];

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		edf_cell #(
			.SLOT(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.wdata(cmd),
			.now(now_q),
			.cand_in(chain[g]),
			.cand_out(chain[g+1]),
			.vld(valid_vec[g])
		);
	end

	assign accept = start && !busy;
	assign bad = (cmd.burst == 16'd0) || (cmd.arrival >= cmd.deadline);
	assign reject = accept && (cmd.opcode == edf_pkg::OP_SUBMIT) && (bad || !free_found);

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_vec[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ctl[i].wr = wr_en && (free_idx == IDX_W'(i));
			ctl[i].clr = clr_en && (best.slot[IDX_W-1:0] == IDX_W'(i));
		end
	end

	always_comb begin
		fin64 = {1'b0, now_q} + {17'd0, best.burst};
		miss = fin64 > {1'b0, best.dl};
		fin_sat = fin64[32] ? '1 : fin64[31:0];
		missed_inc = (missed_q == 16'hFFFF) ? missed_q : missed_q + 16'd1;
		now_inc = (now_q == 32'hFFFF_FFFF) ? now_q : now_q + 32'd1;
		tat = pend_q.finish_time - run_arr_q;
		wt = (tat >= {16'd0, run_burst_q}) ? tat - {16'd0, run_burst_q} : 32'd0;
	end

	// next state and slot controls
	always_comb begin
		state_d = state_q;
		wr_en = 1'b0;
		clr_en = 1'b0;
		case (state_q)
			edf_pkg::ST_IDLE: begin
				if (accept && cmd.opcode == edf_pkg::OP_SUBMIT) begin
					wr_en = !bad && free_found;
				end else if (accept && !halted_q) begin
					state_d = edf_pkg::ST_SCAN;
				end
			end
			edf_pkg::ST_SCAN: begin
				if (cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
					state_d = edf_pkg::ST_DECIDE;
				end
			end
			edf_pkg::ST_DECIDE: begin
				clr_en = best.v;
				if (!best.v) begin
					state_d = edf_pkg::ST_IDLE;
				end else if (miss) begin
					state_d = edf_pkg::ST_SCAN;
				end else begin
					state_d = edf_pkg::ST_FIN;
				end
			end
			edf_pkg::ST_FIN: begin
				state_d = edf_pkg::ST_IDLE;
			end
			default: begin
				state_d = edf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			now_q <= '0;
			missed_q <= '0;
			halted_q <= 1'b0;
			hard_q <= 1'b0;
			pend_v_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			if (psel && penable && pwrite && !paddr[2]) begin
				hard_q <= pwdata[0];
			end
			case (state_q)
				edf_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (reject) begin
						res_v_q <= 1'b1;
					end
				end
				edf_pkg::ST_SCAN: begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
				edf_pkg::ST_DECIDE: begin
					cnt_q <= '0;
					res_v_q <= pend_v_q;
					if (!best.v) begin
						now_q <= now_inc;
						pend_v_q <= 1'b0;
					end else if (miss) begin
						missed_q <= missed_inc;
						if (hard_q) begin
							halted_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
					end else begin
						now_q <= fin_sat;
						pend_v_q <= 1'b1;
					end
				end
				edf_pkg::ST_FIN: begin
					res_v_q <= 1'b1;
					pend_v_q <= 1'b0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			edf_pkg::ST_IDLE: begin
				res_q.kind <= bad ? edf_pkg::KIND_BAD : edf_pkg::KIND_FULL;
				res_q.out_task_id <= cmd.task_id;
				res_q.finish_time <= '0;
				res_q.turnaround <= '0;
				res_q.wait_time <= '0;
				res_q.missed_total <= missed_q;
				res_q.halted_flag <= halted_q;
				res_q.last <= 1'b1;
			end
			edf_pkg::ST_DECIDE: begin
				res_q <= '{kind: pend_q.kind, out_task_id: pend_q.out_task_id,
					finish_time: pend_q.finish_time, turnaround: pend_q.turnaround,
					wait_time: pend_q.wait_time, missed_total: pend_q.missed_total,
					halted_flag: pend_q.halted_flag, last: !best.v};
				pend_q.out_task_id <= best.id;
				pend_q.turnaround <= '0;
				pend_q.wait_time <= '0;
				run_arr_q <= best.arr;
				run_burst_q <= best.burst;
				if (miss) begin
					pend_q.kind <= edf_pkg::KIND_MISS;
					pend_q.finish_time <= '0;
					pend_q.missed_total <= missed_inc;
					pend_q.halted_flag <= halted_q || hard_q;
					pend_q.last <= 1'b0;
				end else begin
					pend_q.kind <= edf_pkg::KIND_DONE;
					pend_q.finish_time <= fin_sat;
					pend_q.missed_total <= missed_q;
					pend_q.halted_flag <= halted_q;
					pend_q.last <= 1'b1;
				end
			end
			edf_pkg::ST_FIN: begin
				res_q <= '{kind: pend_q.kind, out_task_id: pend_q.out_task_id,
					finish_time: pend_q.finish_time, turnaround: tat, wait_time: wt,
					missed_total: pend_q.missed_total, halted_flag: pend_q.halted_flag,
					last: 1'b1};
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign busy = (state_q != edf_pkg::ST_IDLE);
	assign result_valid = res_v_q;
	assign result = res_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, hard_q};

	assign step_go = accept && (cmd.opcode == edf_pkg::OP_STEP) && !halted_q;
	assign done_out = result_valid && (result.kind == edf_pkg::KIND_DONE);

	`include "edf_dispatcher_with_deadline_drop_unit_assert.svh"

	`EDF_ASSERT_NOW(a_done_last, done_out, result.last, "completion not last")
	`EDF_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halted cleared")
	`EDF_ASSERT_NEXT(a_step_busy, step_go, busy, "step not started")
	`EDF_ASSERT_NOW(a_clr_valid, clr_en, best.v, "clear without pick")

endmodule

FILE: sv/edf_cell.sv
// One table slot of the EDF dispatcher chain: holds a task and passes on
// the better of its own task, once arrived, and the incoming candidate. Uses edf_pkg.
module edf_cell #(
	parameter int SLOT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  edf_pkg::cell_ctl_t  ctl,
	input  edf_pkg::in_word_t   wdata,
	input  logic [31:0]         now,
	input  edf_pkg::cand_t      cand_in,
	output edf_pkg::cand_t      cand_out,
	output logic                vld
);

	logic        v_q;
	logic [15:0] id_q;
	logic [15:0] burst_q;
	logic [31:0] arr_q;
	logic [31:0] dl_q;
	logic [7:0]  pr_q;
	logic        elig;
	logic        better;
	edf_pkg::cand_t cand_q;
	edf_pkg::cand_t own;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.wr) begin
			v_q <= 1'b1;
		end else if (ctl.clr) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			id_q <= wdata.task_id;
			burst_q <= wdata.burst;
			arr_q <= wdata.arrival;
			dl_q <= wdata.deadline;
			pr_q <= wdata.priority_req;
		end
	end

	always_comb begin
		elig = v_q && (arr_q <= now);
		better = !cand_in.v || (dl_q < cand_in.dl) ||
			((dl_q == cand_in.dl) && (pr_q < cand_in.pr));
		own.v = 1'b1;
		own.slot = edf_pkg::SLOT_W'(SLOT);
		own.id = id_q;
		own.burst = burst_q;
		own.arr = arr_q;
		own.dl = dl_q;
		own.pr = pr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= (elig && better) ? own : cand_in;
		end
	end

	assign cand_out = cand_q;
	assign vld = v_q;

endmodule

FILE: bench/edf_dispatcher_with_deadline_drop_unit_tb.sv
// Testbench for the EDF dispatcher with deadline drop: directed and random
// submit/step words, checked against a scoreboard that schedules in parallel.
// Depends on edf_pkg and edf_dispatcher_with_deadline_drop_unit.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = edf_pkg::TABLE_DEPTH_DEF;
	localparam logic [2:0] ADDR_HARD_MODE = 3'd0;

	class edf_scoreboard;
		bit hard;
		logic [31:0] tick;
		logic [15:0] misses;
		bit stopped;
		bit occ[DEPTH];
		logic [15:0] s_id[DEPTH];
		logic [15:0] s_burst[DEPTH];
		logic [31:0] s_arr[DEPTH];
		logic [31:0] s_dl[DEPTH];
		logic [7:0] s_pr[DEPTH];
		edf_pkg::out_word_t pending[$];
		int errors;

		function void clear();
			hard = 0; tick = 0; misses = 0; stopped = 0;
			foreach (occ[i]) occ[i] = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void expect_word(edf_pkg::out_word_t r);
			pending = {pending, r};
		endfunction

		function edf_pkg::out_word_t mk(logic [1:0] k, logic [15:0] id, logic [31:0] f,
				logic [31:0] t, logic [31:0] w);
			edf_pkg::out_word_t r;
			r.kind = k; r.out_task_id = id; r.finish_time = f;
			r.turnaround = t; r.wait_time = w; r.missed_total = misses;
			r.halted_flag = stopped; r.last = 1'b0;
			return r;
		endfunction

		function int earliest();
			int b;
			b = -1;
			for (int s = 0; s < DEPTH; s++) begin
				if (!occ[s] || s_arr[s] > tick) continue;
				if (b < 0 || s_dl[s] < s_dl[b] || (s_dl[s] == s_dl[b] && s_pr[s] < s_pr[b]))
					b = s;
			end
			return b;
		endfunction

		function void note_word(edf_pkg::in_word_t w);
			edf_pkg::out_word_t r;
			int s, n, fs;
			logic [32:0] fin;
			logic [31:0] tat;
			n = 0;
			if (w.opcode == edf_pkg::OP_SUBMIT) begin
				if (w.burst == 16'd0 || w.arrival >= w.deadline) begin
					r = mk(edf_pkg::KIND_BAD, w.task_id, 32'd0, 32'd0, 32'd0);
					r.last = 1'b1;
					expect_word(r);
					return;
				end
				fs = -1;
				for (s = 0; s < DEPTH; s++) if (!occ[s] && fs < 0) fs = s;
				if (fs < 0) begin
					r = mk(edf_pkg::KIND_FULL, w.task_id, 32'd0, 32'd0, 32'd0);
					r.last = 1'b1;
					expect_word(r);
					return;
				end
				occ[fs] = 1; s_id[fs] = w.task_id; s_burst[fs] = w.burst;
				s_arr[fs] = w.arrival; s_dl[fs] = w.deadline; s_pr[fs] = w.priority_req;
				return;
			end
			if (stopped) return;
			forever begin
				s = earliest();
				if (s < 0) begin
					if (tick != '1) tick++;
					break;
				end
				fin = {1'b0, tick} + {17'd0, s_burst[s]};
				if (fin > {1'b0, s_dl[s]}) begin
					occ[s] = 0;
					if (misses != '1) misses++;
					if (hard) stopped = 1;
					expect_word(mk(edf_pkg::KIND_MISS, s_id[s], 32'd0, 32'd0, 32'd0));
					n++;
					continue;
				end
				tick = fin[32] ? '1 : fin[31:0];
				tat = tick - s_arr[s];
				occ[s] = 0;
				expect_word(mk(edf_pkg::KIND_DONE, s_id[s], tick, tat,
					(tat >= {16'd0, s_burst[s]}) ? tat - {16'd0, s_burst[s]} : 32'd0));
				n++;
				break;
			end
			if (n > 0) pending[$].last = 1'b1;
		endfunction

		task check_word(edf_pkg::out_word_t got);
			edf_pkg::out_word_t e;
			if (pending.size() == 0) begin
				report_err("unexpected word", got, got);
				return;
			end
			e = pending.pop_front();
			if (got.kind != e.kind || got.out_task_id != e.out_task_id ||
					got.finish_time != e.finish_time || got.turnaround != e.turnaround ||
					got.wait_time != e.wait_time || got.missed_total != e.missed_total ||
					got.halted_flag != e.halted_flag || got.last != e.last)
				report_err("field mismatch", got, e);
		endtask

		task report_err(string what, edf_pkg::out_word_t got, edf_pkg::out_word_t e);
			errors++;
			$display("ERR %0t %s: got %p exp %p", $time, what, got, e);
		endtask
	endclass

	logic clk, arst_n, start, busy, result_valid;
	edf_pkg::in_word_t cmd;
	edf_pkg::out_word_t result;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	edf_scoreboard sb;
	int gap_pct;
	logic [15:0] next_id;

	edf_dispatcher_with_deadline_drop_unit dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) if (arst_n && result_valid) sb.check_word(result);

	task automatic write_hard(bit v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_HARD_MODE;
		pwdata <= {31'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.hard = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send(edf_pkg::in_word_t w);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clk);
		start = 1'b1; cmd = w;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(w);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic submit(logic [15:0] b, logic [31:0] a, logic [31:0] d, logic [7:0] p);
		edf_pkg::in_word_t w;
		w = '{opcode: edf_pkg::OP_SUBMIT, task_id: next_id, burst: b, arrival: a,
			deadline: d, priority_req: p};
		next_id++;
		send(w);
	endtask

	task automatic step_once();
		edf_pkg::in_word_t w;
		w = '0;
		w.opcode = edf_pkg::OP_STEP;
		w.task_id = 16'($urandom);
		w.burst = 16'($urandom);
		w.arrival = $urandom;
		w.deadline = $urandom;
		w.priority_req = 8'($urandom);
		send(w);
	endtask

	task automatic directed();
		logic [31:0] t;
		gap_pct = 0;
		t = sb.tick;
		// zero burst, then arrival at the deadline
		submit(16'd0, t, t + 32'd10, 8'd1);
		submit(16'd3, t + 32'd5, t + 32'd5, 8'd1);
		// fill the table so one step drops all but one task
		for (int i = 0; i < DEPTH - 1; i++) submit(16'd20, t, t + 32'd10, 8'(i));
		submit(16'd1, t, t + 32'd1000, 8'd0);
		submit(16'd2, t, t + 32'd50, 8'd0);
		step_once();
		step_once();
		drain();
	endtask

	task automatic random_phase(int n, int pct);
		logic [31:0] t;
		gap_pct = pct;
		for (int i = 0; i < n; i++) begin
			t = sb.tick;
			case ($urandom_range(9))
				0: submit(16'($urandom), $urandom, $urandom, 8'($urandom));
				1: submit(16'($urandom_range(3)), t + $urandom_range(4),
					t + $urandom_range(4), 8'd0);
				2, 3, 4: submit(16'($urandom_range(1, 6)), t + $urandom_range(5),
					t + $urandom_range(6, 30), 8'($urandom_range(3)));
				default: step_once();
			endcase
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		gap_pct = 0;
		next_id = 16'd1;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed();
		random_phase(35, 0);
		drain();
		random_phase(35, 53);
		random_phase(30, 0);
		random_phase(20, 7);
		drain();
		write_hard(1'b1);
		random_phase(10, 0);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
